// File: hw/rtl/tms_pkg.sv
// Shared types and constants for the tone melody sequencer.
// Used by tms_note_ram, tms_out_skid and tone_melody_sequencer_unit.
`default_nettype none

package tms_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int TICK_WIDTH  = 16;
	localparam int PTR_W       = $clog2(TABLE_DEPTH);
	localparam int WAIT_W      = TICK_WIDTH + 1;
	localparam int FREQ_W      = 16;
	localparam int SONG_W      = 8;
	localparam int GAP_W       = 16;
	localparam int POS_W       = 7;
	localparam int WRAP_MAX    = (TABLE_DEPTH < 128) ? TABLE_DEPTH : 128;

	localparam logic [SONG_W-1:0] SONG_RESET = 8'd1;
	localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd50;

	typedef struct packed {
		logic [FREQ_W-1:0]     freq;
		logic [TICK_WIDTH-1:0] dur;
		logic [TICK_WIDTH-1:0] len;
	} note_t;

	// Packed so that tone_on lands in bit 0 of the output word.
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [FREQ_W-1:0] freq;
		logic              tone_on;
	} result_t;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_PLAY  = 3'd1,
		KIND_PAUSE = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_FF    = 3'd4,
		KIND_WRITE = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		MODE_STOP  = 4'b0001,
		MODE_PLAY  = 4'b0010,
		MODE_PAUSE = 4'b0100,
		MODE_FF    = 4'b1000
	} mode_t;

	typedef enum logic {
		CFG_SONG_LENGTH = 1'b0,
		CFG_NOTE_GAP    = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/tms_note_ram.sv
// Note table: single-port-write, one-read synchronous memory with a registered read.
// Forwards a same-cycle write to the read address. Depends on tms_pkg.
`default_nettype none

module tms_note_ram (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [tms_pkg::PTR_W-1:0] wr_addr,
	input  wire tms_pkg::note_t            wr_data,
	input  wire logic [tms_pkg::PTR_W-1:0] rd_addr,
	output tms_pkg::note_t                 rd_data
);

	tms_pkg::note_t mem [tms_pkg::TABLE_DEPTH];
	tms_pkg::note_t rdata_q;
	tms_pkg::note_t fwd_data_q;
	logic           fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q    <= mem[rd_addr];
		fwd_data_q <= wr_data;
	end

	// Flag a write that collides with the read so the fresh word wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/tms_out_skid.sv
// Two-entry output buffer: output register plus skid register.
// Depends on tms_pkg for the result word.
`default_nettype none

module tms_out_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire tms_pkg::result_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output tms_pkg::result_t      out_data
);

	tms_pkg::result_t out_q;
	tms_pkg::result_t skid_q;
	logic             out_v_q;
	logic             skid_v_q;
	logic             in_fire;
	logic             drain;

	assign in_ready  = !skid_v_q;
	assign in_fire   = in_valid && in_ready;
	assign drain     = out_ready || !out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_v_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tone_melody_sequencer_unit.sv
// Tone melody sequencer: steps a looping note table on a tone output.
// A word's result is computed from the updated state and registered in tms_out_skid.
// Throughput: one word per cycle while the skid register is empty; the table read is prefetched.
// Reset (arst_n low): stopped, counter 0, pointer 1, current note zero, song length 1,
// gap 50. The note table is not cleared and holds garbage until written.
// Depends on tms_pkg, tms_note_ram and tms_out_skid.
`default_nettype none

module tone_melody_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [6:0] note_slot, [22:7] note_length, [38:23] note_duration,
	// [54:39] note_frequency, [55] zero
	input  wire logic [55:0] s_tdata,
	// [2:0] kind
	input  wire logic [2:0]  s_tuser,
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] tone_on, [16:1] tone_frequency, [23:17] note_position
	output logic [23:0]      m_tdata,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam int WRAP_W = tms_pkg::PTR_W + 1;

	// Architectural state
	tms_pkg::mode_t                mode_q, mode_d;
	logic [tms_pkg::WAIT_W-1:0]    wait_q, wait_d;
	logic [tms_pkg::PTR_W-1:0]     ptr_q, ptr_d;
	tms_pkg::note_t                cur_q, cur_d;
	tms_pkg::note_t                e0_q;         // copy of table entry 0 for rewind
	logic [tms_pkg::SONG_W-1:0]    song_q, song_d;
	logic [tms_pkg::GAP_W-1:0]     gap_q;

	// Item decode
	tms_pkg::kind_t                kind;
	logic                          fire;
	logic [tms_pkg::POS_W-1:0]     slot;
	tms_pkg::note_t                wr_note;
	logic                          wr_en;

	// Pointer and wrap logic
	logic [WRAP_W-1:0]             wrap_q, wrap_d;
	logic [tms_pkg::PTR_W-1:0]     peff_q, peff_d;
	logic [WRAP_W-1:0]             step_ptr;
	logic [tms_pkg::PTR_W-1:0]     tick_ptr, stop_ptr;
	tms_pkg::note_t                pref;

	// Counter
	logic [tms_pkg::WAIT_W:0]      sum;
	logic [tms_pkg::WAIT_W-1:0]    wsat;

	// Result
	logic [tms_pkg::TICK_WIDTH-1:0] thr;
	tms_pkg::result_t               res;
	logic                           res_ready;

	assign kind     = tms_pkg::kind_t'(s_tuser);
	assign s_tready = res_ready;
	assign fire     = s_tvalid && res_ready;
	assign slot     = s_tdata[6:0];
	assign wr_note.len  = tms_pkg::TICK_WIDTH'(s_tdata[22:7]);
	assign wr_note.dur  = tms_pkg::TICK_WIDTH'(s_tdata[38:23]);
	assign wr_note.freq = s_tdata[54:39];

	// Wrap point: song length clamped to the table, zero acts as one
	function automatic logic [WRAP_W-1:0] wrap_of(input logic [tms_pkg::SONG_W-1:0] song);
		logic [WRAP_W-1:0] w;
		if (song == '0) begin
			w = WRAP_W'(1);
		end else if (int'(song) > tms_pkg::WRAP_MAX) begin
			w = WRAP_W'(tms_pkg::WRAP_MAX);
		end else begin
			w = WRAP_W'(song);
		end
		return w;
	endfunction

	assign wrap_q = wrap_of(song_q);
	assign wrap_d = wrap_of(song_d);

	// A pointer at or past the wrap point loads entry 0
	assign peff_q = ({1'b0, ptr_q} < wrap_q) ? ptr_q : '0;
	assign peff_d = ({1'b0, ptr_d} < wrap_d) ? ptr_d : '0;

	assign step_ptr = {1'b0, peff_q} + WRAP_W'(1);
	assign tick_ptr = (step_ptr >= wrap_q) ? '0 : step_ptr[tms_pkg::PTR_W-1:0];
	assign stop_ptr = (wrap_q <= WRAP_W'(1)) ? '0 : tms_pkg::PTR_W'(1);

	// Song length as it stands after this cycle's config write
	always_comb begin
		song_d = song_q;
		if (cfg_we && tms_pkg::cfg_idx_t'(cfg_index) == tms_pkg::CFG_SONG_LENGTH) begin
			song_d = cfg_wdata[tms_pkg::SONG_W-1:0];
		end
	end

	// Read the entry at the next effective pointer so it is ready once the pointer register updates
	tms_note_ram u_note_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (slot[tms_pkg::PTR_W-1:0]),
		.wr_data (wr_note),
		.rd_addr (peff_d),
		.rd_data (pref)
	);

	// Tick add, saturate at all ones
	always_comb begin
		sum  = {1'b0, wait_q} + ((mode_q == tms_pkg::MODE_FF) ? (tms_pkg::WAIT_W+1)'(2)
		                                                      : (tms_pkg::WAIT_W+1)'(1));
		wsat = sum[tms_pkg::WAIT_W] ? '1 : sum[tms_pkg::WAIT_W-1:0];
	end

	// Next-state update for one accepted word
	always_comb begin
		mode_d = mode_q;
		wait_d = wait_q;
		ptr_d  = ptr_q;
		cur_d  = cur_q;
		wr_en  = 1'b0;
		if (fire) begin
			case (kind)
				tms_pkg::KIND_TICK: begin
					if (mode_q inside {tms_pkg::MODE_PLAY, tms_pkg::MODE_FF}) begin
						if (wsat >= tms_pkg::WAIT_W'(cur_q.len)) begin
							// advance to the prefetched note
							cur_d  = pref;
							ptr_d  = tick_ptr;
							wait_d = '0;
						end else begin
							wait_d = wsat;
						end
					end
				end
				tms_pkg::KIND_PLAY:  mode_d = tms_pkg::MODE_PLAY;
				tms_pkg::KIND_PAUSE: mode_d = tms_pkg::MODE_PAUSE;
				tms_pkg::KIND_FF:    mode_d = tms_pkg::MODE_FF;
				tms_pkg::KIND_STOP: begin
					// rewind: entry 0 is loaded, so play resumes at entry 1 (entry 0 when the wrap point is one)
					wait_d = '0;
					cur_d  = e0_q;
					ptr_d  = stop_ptr;
					mode_d = tms_pkg::MODE_STOP;
				end
				tms_pkg::KIND_WRITE: begin
					wr_en = (int'(slot) < tms_pkg::TABLE_DEPTH);
				end
				default: begin
					// unknown kinds leave the state alone
				end
			endcase
		end
	end

	// Result from the updated state; a duration not above the gap is silent
	always_comb begin
		thr = (tms_pkg::GAP_W'(cur_d.dur) > gap_q) ? (cur_d.dur - tms_pkg::TICK_WIDTH'(gap_q))
		                                            : '0;
		res.tone_on = (mode_d inside {tms_pkg::MODE_PLAY, tms_pkg::MODE_FF})
		              && (wait_d < tms_pkg::WAIT_W'(thr));
		res.freq    = res.tone_on ? cur_d.freq : '0;
		res.pos     = tms_pkg::POS_W'(ptr_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tms_pkg::MODE_STOP;
			wait_q <= '0;
			ptr_q  <= tms_pkg::PTR_W'(1);
			cur_q  <= '0;
			song_q <= tms_pkg::SONG_RESET;
			gap_q  <= tms_pkg::GAP_RESET;
		end else begin
			mode_q <= mode_d;
			wait_q <= wait_d;
			ptr_q  <= ptr_d;
			cur_q  <= cur_d;
			song_q <= song_d;
			if (cfg_we && tms_pkg::cfg_idx_t'(cfg_index) == tms_pkg::CFG_NOTE_GAP) begin
				gap_q <= cfg_wdata;
			end
		end
	end

	// Shadow of entry 0, so rewind needs no extra read port
	always_ff @(posedge clk) begin
		if (wr_en && slot == '0) begin
			e0_q <= wr_note;
		end
	end

	// Output register plus skid so input keeps flowing under a short stall
	tms_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (res_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
